FILE: rtl/core/mwto_pkg.sv
`default_nettype none

package mwto_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned SAMPLE_W     = 24;   // Q1.23
  localparam int unsigned PHASE_W      = 32;   // signed Q4.28
  localparam int unsigned PHASE_FRAC   = 28;
  localparam int unsigned FREQ_W       = 32;   // unsigned Q24.8
  localparam int unsigned BASE_FREQ_W  = 24;
  localparam int unsigned LVL_CNT_W    = 5;
  localparam int unsigned LOAD_LVL_W   = 4;
  localparam int unsigned LOAD_ENT_W   = 12;
  localparam int unsigned WEIGHT_W     = 16;   // interpolation / crossfade fraction
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;

  // Job fields sized for the largest legal level count (32) and table (65536)
  localparam int unsigned LVL_W        = 5;
  localparam int unsigned ENT_W        = 16;

  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [BASE_FREQ_W-1:0] BASE_FREQ_RST   = 24'd5120;
  localparam logic [LVL_CNT_W-1:0]   LEVEL_COUNT_RST = 5'd11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_FREQ   = 2'd0,
    CFG_LEVEL_COUNT = 2'd1
  } mwto_cfg_idx_e;

  typedef struct packed {
    logic                         action;
    logic signed [PHASE_W-1:0]    phase;
    logic [FREQ_W-1:0]            freq;
    logic [LOAD_LVL_W-1:0]        level;
    logic [LOAD_ENT_W-1:0]        entry_index;
    logic signed [SAMPLE_W-1:0]   entry_value;
  } mwto_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]   sample_out;
  } mwto_out_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic                         we;     // load in range
    logic                         play;
    logic                         last;   // no crossfade partner level
    logic                         oor;    // phase outside [0,1)
    logic [LVL_W-1:0]             lvl;
    logic [ENT_W-1:0]             ent;
    logic [WEIGHT_W-1:0]          fr;
    logic [BASE_FREQ_W-1:0]       rem;    // divider start remainder
    logic [WEIGHT_W-1:0]          nlow;   // divider numerator low bits
    logic signed [SAMPLE_W-1:0]   wdata;
  } mwto_job_t;

endpackage

`default_nettype wire

FILE: rtl/core/mwto_stream_if.sv
`default_nettype none

interface mwto_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mwto_ram.sv
`default_nettype none

module mwto_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/mwto_fifo.sv
`default_nettype none

module mwto_fifo
  import mwto_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire mwto_job_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output mwto_job_t      data_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  mwto_job_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mwto_front.sv
`default_nettype none

module mwto_front
  import mwto_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 4096,
  parameter int unsigned MAX_LEVELS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire mwto_in_t               in_data_i,
  input  wire logic [BASE_FREQ_W-1:0] base_freq_i,
  input  wire logic [LVL_CNT_W-1:0]   level_count_i,
  output logic                        job_valid_o,
  input  wire logic                   job_ready_i,
  output mwto_job_t                   job_o
);

  localparam int unsigned TW = $clog2(TABLE_SIZE);
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned NW = 6;
  localparam int unsigned SW = 56;   // base_freq shifted by up to 31

  // stage A: registered item plus chosen level
  logic            a_valid_q;
  mwto_in_t        a_in_q;
  logic [LW-1:0]   a_idx_q;
  logic            a_last_q;

  logic [NW-1:0]   n_lvl;
  logic [LW-1:0]   sel_idx;
  logic            sel_last;
  logic            found;

  // stage B
  logic [LW-1:0]        s_amt;
  logic [SW-1:0]        f0;
  logic [FREQ_W-1:0]    d_freq;
  logic [FREQ_W+WEIGHT_W-1:0] nsh;
  logic [PHASE_FRAC+TW-1:0]   posv;
  logic                 ld_ok;

  assign in_ready_o  = !a_valid_q || job_ready_i;
  assign job_valid_o = a_valid_q;

  always_comb begin
    if (level_count_i == '0) begin
      n_lvl = NW'(1);
    end else if (NW'(level_count_i) > NW'(MAX_LEVELS)) begin
      n_lvl = NW'(MAX_LEVELS);
    end else begin
      n_lvl = NW'(level_count_i);
    end
    sel_idx = LW'(n_lvl - 1'b1);
    found   = 1'b0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (!found && (NW'(k) < n_lvl) &&
          (SW'(in_data_i.freq) < (SW'(base_freq_i) << k))) begin
        sel_idx = LW'(k);
        found   = 1'b1;
      end
    end
    sel_last = ((NW'(sel_idx) + 1'b1) >= n_lvl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_in_q   <= in_data_i;
      a_idx_q  <= sel_idx;
      a_last_q <= sel_last;
    end
  end

  always_comb begin
    s_amt  = a_idx_q - 1'b1;
    f0     = (a_idx_q == '0) ? '0 : (SW'(base_freq_i) << s_amt);
    d_freq = a_in_q.freq - f0[FREQ_W-1:0];
    nsh    = (a_idx_q == '0) ? {d_freq, {WEIGHT_W{1'b0}}}
                             : ({d_freq, {WEIGHT_W{1'b0}}} >> s_amt);
    posv   = {a_in_q.phase[PHASE_FRAC-1:0], {TW{1'b0}}};
    ld_ok  = (NW'(a_in_q.level) < NW'(MAX_LEVELS)) &&
             ((ENT_W+1)'(a_in_q.entry_index) < (ENT_W+1)'(TABLE_SIZE));

    job_o.we    = a_in_q.action && ld_ok;
    job_o.play  = !a_in_q.action;
    job_o.last  = a_last_q;
    job_o.oor   = (a_in_q.phase[PHASE_W-1:PHASE_FRAC] != '0);
    job_o.fr    = posv[PHASE_FRAC-1:PHASE_FRAC-WEIGHT_W];
    job_o.wdata = a_in_q.entry_value;
    if (a_in_q.action) begin
      job_o.lvl = LVL_W'(a_in_q.level);
      job_o.ent = ENT_W'(a_in_q.entry_index);
    end else begin
      job_o.lvl = LVL_W'(a_idx_q);
      job_o.ent = ENT_W'(posv[PHASE_FRAC+TW-1:PHASE_FRAC]);
    end
    if (a_last_q) begin
      job_o.rem  = '0;
      job_o.nlow = '0;
    end else begin
      job_o.rem  = nsh[WEIGHT_W+BASE_FREQ_W-1:WEIGHT_W];
      job_o.nlow = nsh[WEIGHT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mwto_back.sv
`default_nettype none

module mwto_back
  import mwto_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 4096,
  parameter int unsigned MAX_LEVELS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  input  wire mwto_job_t              job_i,
  output logic                        job_pop_o,
  input  wire logic [BASE_FREQ_W-1:0] base_freq_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output mwto_out_t                   out_data_o
);

  localparam int unsigned TW         = $clog2(TABLE_SIZE);
  localparam int unsigned HW         = TW - 1;
  localparam int unsigned BANK_DEPTH = ((MAX_LEVELS + 1) / 2) * (TABLE_SIZE / 2);
  localparam int unsigned AW         = $clog2(BANK_DEPTH);
  localparam int unsigned DIV_STEPS  = WEIGHT_W;
  localparam int unsigned VW         = 42;   // level value, scale 2^-39
  localparam int unsigned PWD        = 60;   // crossfade product

  typedef struct packed {
    logic                     last;
    logic                     oor;
    logic                     lb;     // level bank of the chosen level
    logic                     eb;     // entry bank of the lower entry
    logic [WEIGHT_W-1:0]      fr;
    logic [WEIGHT_W-1:0]      q;
    logic [BASE_FREQ_W-1:0]   rem;
    logic [WEIGHT_W-1:0]      nlow;
    logic signed [VW-1:0]     v0;
    logic signed [VW-1:0]     v1;
  } stage_t;

  logic                    en;
  stage_t                  st_q [DIV_STEPS+1];
  stage_t                  st_d [DIV_STEPS+1];
  logic [DIV_STEPS:0]      st_vld_q;
  logic [BASE_FREQ_W:0]    trial [DIV_STEPS];

  logic [AW-1:0]           bank_addr [4];
  logic [3:0]              bank_we;
  logic [SAMPLE_W-1:0]     rd [4];
  logic [ENT_W-1:0]        ent_nxt;
  logic [LVL_W-1:0]        lvl_nxt;

  logic signed [SAMPLE_W-1:0] x00, x01, x10, x11;
  logic signed [WEIGHT_W+1:0] c_lo, c_hi;

  logic [WEIGHT_W-1:0]        w;
  logic signed [WEIGHT_W+1:0] cw_lo, cw_hi;
  logic                       prod_vld_q;
  logic signed [PWD-1:0]      pa_q, pb_q;
  logic signed [PWD-1:0]      acc;
  logic signed [PWD-33:0]     res;

  logic                       out_vld_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic signed [SAMPLE_W-1:0] sat;

  assign en        = !out_vld_q || out_ready_i;
  assign job_pop_o = en && job_valid_i;

  // bank b = {level parity, entry parity}; neighbour level / entry fall in the other bank
  always_comb begin
    ent_nxt = ENT_W'(TW'(job_i.ent[TW-1:0] + 1'b1));
    lvl_nxt = job_i.lvl + 1'b1;
    for (int b = 0; b < 4; b++) begin
      logic [LVL_W-1:0] lv;
      logic [ENT_W-1:0] en_ix;
      lv    = (job_i.lvl[0] == b[1]) ? job_i.lvl : lvl_nxt;
      en_ix = (job_i.ent[0] == b[0]) ? job_i.ent : ent_nxt;
      bank_addr[b] = (AW'(lv >> 1) << HW) | AW'(en_ix[TW-1:1]);
      bank_we[b]   = job_i.we && (job_i.lvl[0] == b[1]) && (job_i.ent[0] == b[0]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    mwto_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (job_pop_o),
      .we_i    (bank_we[g]),
      .addr_i  (bank_addr[g]),
      .wdata_i (job_i.wdata),
      .rdata_o (rd[g])
    );
  end

  // interpolation on stage 0, one divider bit per stage
  always_comb begin
    x00  = rd[{st_q[0].lb,  st_q[0].eb}];
    x01  = rd[{st_q[0].lb, ~st_q[0].eb}];
    x10  = rd[{~st_q[0].lb,  st_q[0].eb}];
    x11  = rd[{~st_q[0].lb, ~st_q[0].eb}];
    c_lo = {1'b0, (WEIGHT_W+1)'(1 << WEIGHT_W) - (WEIGHT_W+1)'(st_q[0].fr)};
    c_hi = {2'b00, st_q[0].fr};

    st_d[0] = st_q[0];
    for (int k = 0; k < DIV_STEPS; k++) begin
      st_d[k+1] = st_q[k];
      trial[k]  = {st_q[k].rem, st_q[k].nlow[DIV_STEPS-1-k]};
      if (trial[k] >= {1'b0, base_freq_i}) begin
        st_d[k+1].rem = BASE_FREQ_W'(trial[k] - {1'b0, base_freq_i});
        st_d[k+1].q   = {st_q[k].q[WEIGHT_W-2:0], 1'b1};
      end else begin
        st_d[k+1].rem = trial[k][BASE_FREQ_W-1:0];
        st_d[k+1].q   = {st_q[k].q[WEIGHT_W-2:0], 1'b0};
      end
    end

    if (st_q[0].oor) begin
      st_d[1].v0 = '0;
      st_d[1].v1 = '0;
    end else begin
      st_d[1].v0 = x00 * c_lo + x01 * c_hi;
      if (st_q[0].last) begin
        st_d[1].v1 = '0;
      end else begin
        st_d[1].v1 = x10 * c_lo + x11 * c_hi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q   <= '0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      st_vld_q   <= {st_vld_q[DIV_STEPS-1:0], job_valid_i && job_i.play};
      prod_vld_q <= st_vld_q[DIV_STEPS];
      out_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0].last <= job_i.last;
      st_q[0].oor  <= job_i.oor;
      st_q[0].lb   <= job_i.lvl[0];
      st_q[0].eb   <= job_i.ent[0];
      st_q[0].fr   <= job_i.fr;
      st_q[0].q    <= '0;
      st_q[0].rem  <= job_i.rem;
      st_q[0].nlow <= job_i.nlow;
      st_q[0].v0   <= '0;
      st_q[0].v1   <= '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        st_q[k] <= st_d[k];
      end
      pa_q  <= st_q[DIV_STEPS].v0 * cw_lo;
      pb_q  <= st_q[DIV_STEPS].v1 * cw_hi;
      out_q <= sat;
    end
  end

  // crossfade weight, then floor to Q1.23 and saturate
  always_comb begin
    w     = st_q[DIV_STEPS].last ? '0 : st_q[DIV_STEPS].q;
    cw_lo = {1'b0, (WEIGHT_W+1)'(1 << WEIGHT_W) - (WEIGHT_W+1)'(w)};
    cw_hi = {2'b00, w};
    acc   = pa_q + pb_q;
    res   = acc[PWD-1:32];
    if (res > (PWD-32)'(signed'(24'sh7FFFFF))) begin
      sat = 24'sh7FFFFF;
    end else if (res < (PWD-32)'(signed'(24'sh800000))) begin
      sat = 24'sh800000;
    end else begin
      sat = res[SAMPLE_W-1:0];
    end
  end

  assign out_valid_o           = out_vld_q;
  assign out_data_o.sample_out = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/mipmap_wavetable_oscillator.sv
`default_nettype none
// Channel  | Dir | Payload                                          | Transfer
// in_if    | in  | action, phase, freq, level, entry_index, value   | valid & ready
// out_if   | out | sample_out (one per play item)                   | valid & ready
// cfg      | in  | cfg_idx_i, cfg_data_i                            | cfg_we_i
//
// Throughput one item per cycle while out_if is not stalled. A play item passes one front
// register, the queue, table read, 16 weight-divider stages, crossfade product
// and the output register. Loads write the table as they leave the queue.
// Reset clears handshake state and config registers; table contents are
// undefined until loaded. An output stall freezes the back pipeline; the front
// keeps taking items until the queue fills.
module mipmap_wavetable_oscillator
  import mwto_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 4096,   // power of two, 16..65536
  parameter int unsigned MAX_LEVELS = 16      // 1..32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mwto_stream_if.sink                in_if,
  mwto_stream_if.source              out_if,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Config registers; the user must write them only while the block is idle (not enforced here)
  logic [BASE_FREQ_W-1:0] base_freq_q, base_freq_d;
  logic [LVL_CNT_W-1:0]   level_count_q, level_count_d;

  always_comb begin
    base_freq_d   = base_freq_q;
    level_count_d = level_count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_FREQ:   base_freq_d   = cfg_data_i[BASE_FREQ_W-1:0];
        CFG_LEVEL_COUNT: level_count_d = cfg_data_i[LVL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_freq_q   <= BASE_FREQ_RST;
      level_count_q <= LEVEL_COUNT_RST;
    end else begin
      base_freq_q   <= base_freq_d;
      level_count_q <= level_count_d;
    end
  end

  // Front: level pick, weight-divider operands, table position
  logic      job_valid, q_full, q_empty, q_pop;
  mwto_job_t job_in, job_out;

  mwto_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_o    (in_if.ready),
    .in_data_i     (in_if.payload),
    .base_freq_i   (base_freq_q),
    .level_count_i (level_count_q),
    .job_valid_o   (job_valid),
    .job_ready_i   (!q_full),
    .job_o         (job_in)
  );

  // Short queue lets the front run while the output is stalled
  mwto_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  // Back: banked table access, interpolation, divider, crossfade
  mwto_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .base_freq_i (base_freq_q),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.payload)
  );

endmodule

`default_nettype wire
